[hdl/rtttl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtttl_pkg
// shared constants, types and the pitch table of the ringtone parser
// ----------------------------------------------------------------------------
package rtttl_pkg;

    localparam int NUMBER_WIDTH = 16;
    localparam int DIV_WIDTH    = 18;
    localparam int CNT_WIDTH    = $clog2(DIV_WIDTH);
    localparam int DUR_WIDTH    = 19;
    localparam int FREQ_WIDTH   = 12;

    localparam logic [NUMBER_WIDTH-1:0] NUMBER_MAX = {NUMBER_WIDTH{1'b1}};
    localparam logic [NUMBER_WIDTH-1:0] DEFAULT_BPM = NUMBER_WIDTH'(63);
    localparam logic [DIV_WIDTH-1:0]    MS_PER_MIN  = DIV_WIDTH'(60000);
    localparam logic [7:0]              DEFAULT_LEN = 8'd4;
    localparam logic [2:0]              HDR_OCTAVE  = 3'd6;
    localparam logic [7:0]              TABLE_FIRST = 8'd49;
    localparam logic [7:0]              TABLE_LAST  = 8'd96;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;

    typedef struct packed {
        logic                    start;
        logic [DIV_WIDTH-1:0]    dividend;
        logic [NUMBER_WIDTH-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_WIDTH-1:0] quotient;
    } t_div_rsp;

    function automatic logic [FREQ_WIDTH-1:0] pitch_hz(input logic [5:0] idx);
        logic [FREQ_WIDTH-1:0] f;
        case (idx)
            6'd0:  f = 12'd262;  6'd1:  f = 12'd277;  6'd2:  f = 12'd294;
            6'd3:  f = 12'd311;  6'd4:  f = 12'd330;  6'd5:  f = 12'd349;
            6'd6:  f = 12'd370;  6'd7:  f = 12'd392;  6'd8:  f = 12'd415;
            6'd9:  f = 12'd440;  6'd10: f = 12'd466;  6'd11: f = 12'd494;
            6'd12: f = 12'd523;  6'd13: f = 12'd554;  6'd14: f = 12'd587;
            6'd15: f = 12'd622;  6'd16: f = 12'd659;  6'd17: f = 12'd698;
            6'd18: f = 12'd740;  6'd19: f = 12'd784;  6'd20: f = 12'd831;
            6'd21: f = 12'd880;  6'd22: f = 12'd932;  6'd23: f = 12'd988;
            6'd24: f = 12'd1047; 6'd25: f = 12'd1109; 6'd26: f = 12'd1175;
            6'd27: f = 12'd1245; 6'd28: f = 12'd1319; 6'd29: f = 12'd1397;
            6'd30: f = 12'd1480; 6'd31: f = 12'd1568; 6'd32: f = 12'd1661;
            6'd33: f = 12'd1760; 6'd34: f = 12'd1865; 6'd35: f = 12'd1976;
            6'd36: f = 12'd2093; 6'd37: f = 12'd2217; 6'd38: f = 12'd2349;
            6'd39: f = 12'd2489; 6'd40: f = 12'd2637; 6'd41: f = 12'd2794;
            6'd42: f = 12'd2960; 6'd43: f = 12'd3136; 6'd44: f = 12'd3322;
            6'd45: f = 12'd3520; 6'd46: f = 12'd3729; 6'd47: f = 12'd3951;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

[hdl/rtttl_melody_parser.sv]
`timescale 1ns / 1ps
// a character that sets the tempo or ends a note also takes a pass through the
// bit-serial divider, which forms the 18-bit quotient one bit at a time
// once its division finishes and the previous note has been taken, a note result is
// loaded into an output register and waits there; the next character is taken while it waits
// synchronous active-low reset restores the header defaults and the name-skip phase,
// the octave shift register resets to 0 and survives the end of a song
// ----------------------------------------------------------------------------
// rtttl_melody_parser
// character-serial ringtone text parser giving one note per comma-separated entry
// ----------------------------------------------------------------------------
module rtttl_melody_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_data,
    input  logic                               i_char_valid,
    output logic                               o_char_ready,
    input  logic [7:0]                         i_char_code,
    input  logic                               i_last_char,
    output logic                               o_note_valid,
    input  logic                               i_note_ready,
    output logic [rtttl_pkg::FREQ_WIDTH-1:0]   o_frequency_hz,
    output logic [rtttl_pkg::DUR_WIDTH-1:0]    o_duration_ms,
    output logic                               o_is_rest,
    output logic                               o_out_of_range,
    output logic                               o_last_note
);

    localparam int NW = rtttl_pkg::NUMBER_WIDTH;

    typedef enum logic [4:0] {
        PH_NAME, PH_D_KEY, PH_D_EQ, PH_D_NUM, PH_O_KEY, PH_O_EQ, PH_O_VAL, PH_O_SEP,
        PH_B_KEY, PH_B_EQ, PH_B_NUM, PH_N_LEAD, PH_N_DIGITS, PH_N_SHARP, PH_N_DOT,
        PH_N_SCALE, PH_N_SEP
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE, S_STEP, S_DIVW, S_DIVN, S_EMIT, S_FIN
    } t_state;

    t_state                              r_state;
    t_phase                              r_phase;
    logic [1:0]                          r_shift;
    logic [7:0]                          r_char;
    logic                                r_last;
    logic                                r_zero;
    logic                                r_emitted;
    logic                                r_again;
    logic [7:0]                          r_dlen;
    logic [2:0]                          r_doct;
    logic [NW-1:0]                       r_tempo;
    logic [rtttl_pkg::DIV_WIDTH-1:0]     r_whole;
    logic [NW-1:0]                       r_acc;
    logic [3:0]                          r_semi;
    logic                                r_dot;
    logic [3:0]                          r_oct;
    rtttl_pkg::t_div_req                 r_div_req;
    rtttl_pkg::t_div_rsp                 div_rsp;

    logic [NW-1:0]                       acc_next;
    logic [NW+3:0]                       acc_prod;
    logic                                is_digit;
    logic [3:0]                          letter_code;
    logic [7:0]                          tab_pos;
    logic                                in_table;
    logic [rtttl_pkg::DUR_WIDTH-1:0]     dur;

    rtttl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    assign is_digit = (r_char >= rtttl_pkg::CH_ZERO) && (r_char <= rtttl_pkg::CH_NINE);
    assign acc_prod = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + (NW+4)'(r_char[3:0]);
    assign acc_next = (acc_prod > (NW+4)'(rtttl_pkg::NUMBER_MAX)) ? rtttl_pkg::NUMBER_MAX
                                                                   : acc_prod[NW-1:0];

    always_comb begin
        case (r_char)
            rtttl_pkg::CH_C: letter_code = 4'd1;
            rtttl_pkg::CH_D: letter_code = 4'd3;
            rtttl_pkg::CH_E: letter_code = 4'd5;
            rtttl_pkg::CH_F: letter_code = 4'd6;
            rtttl_pkg::CH_G: letter_code = 4'd8;
            rtttl_pkg::CH_A: letter_code = 4'd10;
            rtttl_pkg::CH_B: letter_code = 4'd12;
            default:         letter_code = 4'd0;
        endcase
    end

    assign tab_pos  = {1'b0, r_oct, 3'b000} + {2'b00, r_oct, 2'b00} + {4'b0000, r_semi};
    assign in_table = (tab_pos >= rtttl_pkg::TABLE_FIRST) && (tab_pos <= rtttl_pkg::TABLE_LAST);
    assign dur      = rtttl_pkg::DUR_WIDTH'(div_rsp.quotient)
                    + (r_dot ? rtttl_pkg::DUR_WIDTH'(div_rsp.quotient[rtttl_pkg::DIV_WIDTH-1:1])
                             : '0);

    assign o_cfg_ready  = 1'b1;
    assign o_char_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_phase         <= PH_NAME;
            r_shift         <= 2'd0;
            r_dlen          <= rtttl_pkg::DEFAULT_LEN;
            r_doct          <= rtttl_pkg::HDR_OCTAVE;
            r_tempo         <= rtttl_pkg::DEFAULT_BPM;
            r_whole         <= '0;
            r_acc           <= '0;
            r_semi          <= '0;
            r_dot           <= 1'b0;
            r_oct           <= '0;
            r_last          <= 1'b0;
            r_zero          <= 1'b0;
            r_emitted       <= 1'b0;
            r_again         <= 1'b0;
            r_div_req.start <= 1'b0;
            o_note_valid    <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            if (i_cfg_valid) begin
                r_shift <= i_cfg_data;
            end
            if (o_note_valid && i_note_ready) begin
                o_note_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_char_valid) begin
                        r_char    <= i_char_code;
                        r_last    <= i_last_char;
                        r_zero    <= 1'b0;
                        r_emitted <= 1'b0;
                        r_state   <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_state <= S_FIN;
                    case (r_phase)
                        PH_NAME: begin
                            if (r_char == rtttl_pkg::CH_COLON) r_phase <= PH_D_KEY;
                        end
                        PH_D_KEY: begin
                            if (r_char == rtttl_pkg::CH_D) begin
                                r_phase <= PH_D_EQ;
                            end else if (r_char != rtttl_pkg::CH_SPACE) begin
                                r_phase <= PH_O_KEY;
                                r_state <= S_STEP;
                            end
                        end
                        PH_D_EQ: begin
                            r_acc   <= '0;
                            r_phase <= PH_D_NUM;
                        end
                        PH_D_NUM: begin
                            if (is_digit) begin
                                r_acc <= acc_next;
                            end else begin
                                if (r_acc != '0) begin
                                    r_dlen <= (r_acc > NW'(255)) ? 8'd255 : r_acc[7:0];
                                end
                                r_acc   <= '0;
                                r_phase <= PH_O_KEY;
                            end
                        end
                        PH_O_KEY: begin
                            if (r_char == rtttl_pkg::CH_O) begin
                                r_phase <= PH_O_EQ;
                            end else if (r_char != rtttl_pkg::CH_SPACE) begin
                                r_phase <= PH_B_KEY;
                                r_state <= S_STEP;
                            end
                        end
                        PH_O_EQ: r_phase <= PH_O_VAL;
                        PH_O_VAL: begin
                            if (r_char >= rtttl_pkg::CH_THREE &&
                                r_char <= rtttl_pkg::CH_SEVEN) begin
                                r_doct <= r_char[2:0];
                            end
                            r_phase <= PH_O_SEP;
                        end
                        PH_O_SEP: r_phase <= PH_B_KEY;
                        PH_B_KEY: begin
                            if (r_char == rtttl_pkg::CH_B) begin
                                r_phase <= PH_B_EQ;
                            end else if (r_char != rtttl_pkg::CH_SPACE) begin
                                r_div_req.start    <= 1'b1;
                                r_div_req.dividend <= rtttl_pkg::MS_PER_MIN;
                                r_div_req.divisor  <= (r_tempo == '0) ? rtttl_pkg::DEFAULT_BPM
                                                                      : r_tempo;
                                r_again <= 1'b1;
                                r_phase <= PH_N_LEAD;
                                r_state <= S_DIVW;
                            end
                        end
                        PH_B_EQ: begin
                            r_acc   <= '0;
                            r_phase <= PH_B_NUM;
                        end
                        PH_B_NUM: begin
                            if (is_digit) begin
                                r_acc <= acc_next;
                            end else begin
                                r_tempo            <= r_acc;
                                r_acc              <= '0;
                                r_div_req.start    <= 1'b1;
                                r_div_req.dividend <= rtttl_pkg::MS_PER_MIN;
                                r_div_req.divisor  <= (r_acc == '0) ? rtttl_pkg::DEFAULT_BPM
                                                                    : r_acc;
                                r_again <= 1'b0;
                                r_phase <= PH_N_LEAD;
                                r_state <= S_DIVW;
                            end
                        end
                        PH_N_LEAD, PH_N_DIGITS: begin
                            if (is_digit) begin
                                r_acc   <= acc_next;
                                r_phase <= PH_N_DIGITS;
                            end else if (!(r_phase == PH_N_LEAD &&
                                           r_char == rtttl_pkg::CH_SPACE)) begin
                                r_semi  <= letter_code;
                                r_dot   <= 1'b0;
                                r_phase <= PH_N_SHARP;
                            end
                        end
                        PH_N_SHARP: begin
                            r_phase <= PH_N_DOT;
                            if (r_char == rtttl_pkg::CH_SHARP) r_semi <= r_semi + 4'd1;
                            else r_state <= S_STEP;
                        end
                        PH_N_DOT: begin
                            r_phase <= PH_N_SCALE;
                            if (r_char == rtttl_pkg::CH_DOT) r_dot <= 1'b1;
                            else r_state <= S_STEP;
                        end
                        PH_N_SCALE: begin
                            r_phase <= PH_N_SEP;
                            if (is_digit) begin
                                r_oct <= r_char[3:0] + {2'b00, r_shift};
                            end else begin
                                r_oct   <= {1'b0, r_doct} + {2'b00, r_shift};
                                r_state <= S_STEP;
                            end
                        end
                        PH_N_SEP: begin
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= r_whole;
                            r_div_req.divisor  <= (r_acc != '0) ? r_acc : NW'(r_dlen);
                            r_again <= (r_char != rtttl_pkg::CH_COMMA);
                            r_phase <= PH_N_LEAD;
                            r_state <= S_DIVN;
                        end
                        default: r_phase <= PH_NAME;
                    endcase
                end
                S_DIVW: begin
                    if (div_rsp.done) begin
                        r_whole <= {div_rsp.quotient[rtttl_pkg::DIV_WIDTH-3:0], 2'b00};
                        r_state <= r_again ? S_STEP : S_FIN;
                    end
                end
                S_DIVN: begin
                    if (div_rsp.done) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!o_note_valid) begin
                        o_note_valid   <= 1'b1;
                        o_duration_ms  <= dur;
                        o_is_rest      <= (r_semi == '0);
                        o_out_of_range <= (r_semi != '0) && !in_table;
                        o_frequency_hz <= (r_semi != '0 && in_table)
                                        ? rtttl_pkg::pitch_hz(6'(tab_pos - rtttl_pkg::TABLE_FIRST))
                                        : '0;
                        o_last_note    <= r_last;
                        r_acc          <= '0;
                        r_dot          <= 1'b0;
                        r_semi         <= '0;
                        r_emitted      <= 1'b1;
                        r_state        <= r_again ? S_STEP : S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_last && !r_emitted && !r_zero &&
                        (r_phase == PH_N_SHARP || r_phase == PH_N_DOT ||
                         r_phase == PH_N_SCALE || r_phase == PH_N_SEP)) begin
                        r_char  <= '0;
                        r_zero  <= 1'b1;
                        r_state <= S_STEP;
                    end else begin
                        if (r_last) begin
                            r_phase <= PH_NAME;
                            r_dlen  <= rtttl_pkg::DEFAULT_LEN;
                            r_doct  <= rtttl_pkg::HDR_OCTAVE;
                            r_tempo <= rtttl_pkg::DEFAULT_BPM;
                            r_whole <= '0;
                            r_acc   <= '0;
                            r_semi  <= '0;
                            r_dot   <= 1'b0;
                            r_oct   <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !r_emitted)
        else $error("second note for one character");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIVW || r_state == S_DIVN))
        else $error("divider finished while not awaited");
    a_zero_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zero |-> r_last)
        else $error("closing pass without final character");
    a_rest_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_note_valid && (o_is_rest || o_out_of_range)) |-> (o_frequency_hz == '0))
        else $error("tone on a rest or out-of-range note");
`endif

endmodule

[hdl/rtttl_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtttl_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rtttl_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rtttl_pkg::t_div_req i_req,
    output rtttl_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [rtttl_pkg::CNT_WIDTH-1:0]     r_cnt;
    logic [rtttl_pkg::NUMBER_WIDTH-1:0]  r_rem;
    logic [rtttl_pkg::DIV_WIDTH-1:0]     r_quo;
    logic [rtttl_pkg::NUMBER_WIDTH-1:0]  r_div;
    logic [rtttl_pkg::NUMBER_WIDTH:0]    trial;
    logic                                ge;

    assign trial = {r_rem, r_quo[rtttl_pkg::DIV_WIDTH-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= ge ? rtttl_pkg::NUMBER_WIDTH'(trial - {1'b0, r_div})
                            : trial[rtttl_pkg::NUMBER_WIDTH-1:0];
                r_quo <= {r_quo[rtttl_pkg::DIV_WIDTH-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rtttl_pkg::CNT_WIDTH'(rtttl_pkg::DIV_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
